[sv/indexed_list_buffer_top_assert.svh]
// Assertion macros for the indexed list buffer
`ifndef INDEXED_LIST_BUFFER_TOP_ASSERT_SVH
`define INDEXED_LIST_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define ILB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define ILB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ilb_pkg.sv]
// Package: widths, codes and cell control type of the indexed list buffer
`timescale 1ns / 1ps
package ilb_pkg;
    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int TYPE_W   = 3;
    localparam int POS_W    = 8;
    localparam int STAT_W   = 2;
    localparam int OCNT_W   = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic [TYPE_W-1:0] REQ_READ      = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_INS_FRONT = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_INS_BACK  = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_INS_AT    = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_DELETE    = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] DATA_NONE = '1;

    typedef logic [CMP_W-1:0] t_cmp;

    typedef struct packed {
        logic              ins;
        logic              del;
        t_cmp              pos;
        logic [DATA_W-1:0] value;
    } t_cell_ctrl;
endpackage

[sv/ilb_if.sv]
// Interfaces: request and response channels of the indexed list buffer
`timescale 1ns / 1ps
interface ilb_req_if;
    import ilb_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [TYPE_W-1:0]        req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, output req_type, output position, output item_value,
                    input ready);
    modport sink (input valid, input req_type, input position, input item_value,
                  output ready);
endinterface

interface ilb_rsp_if;
    import ilb_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_data;
    logic [STAT_W-1:0]        status;
    logic [OCNT_W-1:0]        item_count;

    modport source (output valid, output read_data, output status, output item_count,
                    input ready);
    modport sink (input valid, input read_data, input status, input item_count,
                  output ready);
endinterface

[sv/indexed_list_buffer_top.sv]
// Top level: request decode, count, row of list cells and response register
//
//   channel | dir | carries
//   i_req   | in  | req_type, position, item_value
//   o_rsp   | out | read_data, status, item_count
//
// One item per cycle unless o_rsp stalls; decode, cell shift, read select on accept.
// The response register holds the result; a new item enters while it is taken.
// Throughput is set by the single response register; the response is registered.
// Synchronous active-low reset clears the count and the response valid;
// cell contents are undefined until written.
`timescale 1ns / 1ps
module indexed_list_buffer_top
    import ilb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    ilb_req_if.sink   i_req,
    ilb_rsp_if.source o_rsp
);
    `include "indexed_list_buffer_top_assert.svh"

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_valid;
    logic [DATA_W-1:0] r_read_data;
    logic [STAT_W-1:0] r_status;
    logic [OCNT_W-1:0] r_item_count;

    logic              w_accept;
    logic              w_full;
    logic              w_ins;
    logic              w_del;
    logic              w_rd_ok;
    logic [STAT_W-1:0] w_status;
    t_cmp              w_pos;
    t_cmp              w_cnt;
    t_cmp              w_eff_pos;
    t_cell_ctrl        w_ctrl;
    logic [DATA_W-1:0] w_rd_or;
    logic [DATA_W-1:0] w_data [CAPACITY];
    logic [DATA_W-1:0] w_rd   [CAPACITY];

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_pos       = t_cmp'(i_req.position);
    assign w_cnt       = t_cmp'(r_count);
    assign w_full      = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        w_status  = ST_DONE;
        w_ins     = 1'b0;
        w_del     = 1'b0;
        w_rd_ok   = 1'b0;
        w_eff_pos = w_pos;
        unique case (i_req.req_type) inside
            REQ_READ: begin
                if (w_pos < w_cnt) begin
                    w_rd_ok = 1'b1;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            REQ_INS_FRONT, REQ_INS_BACK: begin
                w_eff_pos = (i_req.req_type == REQ_INS_FRONT) ? '0 : w_cnt;
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            REQ_INS_AT: begin
                if (w_pos > w_cnt) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            REQ_DELETE: begin
                if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_del = 1'b1;
                end
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
    end

    assign w_ctrl.ins   = w_accept && w_ins;
    assign w_ctrl.del   = w_accept && w_del;
    assign w_ctrl.pos   = w_eff_pos;
    assign w_ctrl.value = i_req.item_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ilb_cell u_cell (
            .i_clk     (i_clk),
            .i_index   (t_cmp'(g)),
            .i_ctrl    (w_ctrl),
            .i_prev    ((g == 0) ? w_data[0] : w_data[(g == 0) ? 0 : g - 1]),
            .i_next    ((g == CAPACITY - 1) ? w_data[g] : w_data[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data    (w_data[g]),
            .o_rd_data (w_rd[g])
        );
    end

    always_comb begin
        w_rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd_or = w_rd_or | w_rd[i];
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_data  <= w_rd_ok ? w_rd_or : DATA_NONE;
            r_status     <= w_status;
            r_item_count <= OCNT_W'(n_count);
        end
    end

    assign o_rsp.valid      = r_valid;
    assign o_rsp.read_data  = r_read_data;
    assign o_rsp.status     = r_status;
    assign o_rsp.item_count = r_item_count;

    `ILB_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `ILB_ASSERT_NOW(a_full_only_at_cap, w_accept && w_status == ST_FULL, w_full, "full flagged below capacity")
    `ILB_ASSERT_NEXT(a_ins_counts, w_ctrl.ins, r_count == $past(r_count) + CNT_W'(1), "insert not counted once")
    `ILB_ASSERT_NEXT(a_del_counts, w_ctrl.del, r_count == $past(r_count) - CNT_W'(1), "delete not counted")
endmodule

[sv/ilb_cell.sv]
// Cell: one list entry that shifts with its neighbors on insert and delete
`timescale 1ns / 1ps
module ilb_cell
    import ilb_pkg::*;
(
    input  logic              i_clk,
    input  t_cmp              i_index,
    input  t_cell_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_prev,
    input  logic [DATA_W-1:0] i_next,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_rd_data
);
    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (i_index > i_ctrl.pos) begin
                n_data = i_prev;
            end else if (i_index == i_ctrl.pos) begin
                n_data = i_ctrl.value;
            end
        end else if (i_ctrl.del) begin
            if (i_index >= i_ctrl.pos) begin
                n_data = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    assign o_rd_data = (i_index == i_ctrl.pos) ? r_data : '0;
endmodule
